/* design/lzw_pkg.sv */
// Package for the LZW stream encoder: widths, shared structs and constants.
// Used by every design module but lzw_ram and the channel interfaces; no dependencies.
`default_nettype none
package lzw_pkg;
	localparam int CODE_W   = 12;              // built maximum code width
	localparam int KEY_W    = CODE_W + 8;      // {prefix, byte}
	localparam int DEPTH    = 1 << CODE_W;     // hash table slots
	localparam int NC_W     = CODE_W + 1;      // next-code counter
	localparam int CW_W     = 5;               // code width field
	localparam int TAG_W    = 8;               // epoch tag
	localparam int SLOT_W   = TAG_W + CODE_W + KEY_W;
	localparam int ACC_W    = CODE_W + 7;      // packer accumulator
	localparam int CNT_W    = $clog2(ACC_W + 1);
	localparam int ADDR_W   = 3;               // APB byte address

	localparam logic [TAG_W-1:0] TAG_MAX   = {TAG_W{1'b1}};
	localparam logic [TAG_W-1:0] TAG_EMPTY = '0;
	localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
	localparam logic [NC_W-1:0]  FIRST_CODE = NC_W'(256);
	localparam logic [CW_W-1:0]  MIN_WIDTH  = CW_W'(9);
	localparam logic [CW_W-1:0]  MAX_WIDTH  = CW_W'(CODE_W);
	localparam logic [4:0]       WIDTH_CAP_RST = 5'd12;

	localparam logic [ADDR_W-1:0] REG_WIDTH_CAP = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] REG_FULL_MODE = ADDR_W'(4);

	typedef struct packed {
		logic [4:0] width_cap;
		logic       reset_on_full;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
		logic [CW_W-1:0]   width;
		logic              flush;
	} code_req_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [CODE_W-1:0] code;
		logic [KEY_W-1:0]  key;
	} slot_t;
endpackage
`default_nettype wire

/* design/lzw_chan_if.sv */
// Valid/ready channel interfaces for the encoder's byte input and output.
// No dependencies.
`default_nettype none
interface lzw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface lzw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;
	modport source (output valid, out_byte, last_out, input ready);
	modport sink   (input valid, out_byte, last_out, output ready);
endinterface
`default_nettype wire

/* design/lzw_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
`default_nettype none
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* design/lzw_front.sv */
// Front end: APB config registers and a two-entry input item queue.
// Depends on lzw_pkg and lzw_chan_if.
`default_nettype none
module lzw_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	lzw_in_if.sink                          in_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lzw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output lzw_pkg::cfg_t                   cfg,
	output logic                            head_valid,
	output lzw_pkg::item_t                  head,
	input  wire logic                       pop
);
	lzw_pkg::cfg_t  cfg_q;
	lzw_pkg::item_t q_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_cap     <= lzw_pkg::WIDTH_CAP_RST;
			cfg_q.reset_on_full <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				lzw_pkg::REG_WIDTH_CAP: cfg_q.width_cap     <= pwdata[4:0];
				lzw_pkg::REG_FULL_MODE: cfg_q.reset_on_full <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			lzw_pkg::REG_WIDTH_CAP: prdata = {27'd0, cfg_q.width_cap};
			lzw_pkg::REG_FULL_MODE: prdata = {31'd0, cfg_q.reset_on_full};
			default:                prdata = '0;
		endcase
	end

	assign cfg         = cfg_q;
	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (cnt_q != 2'd0);
	assign head        = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{data_byte: in_ch.data_byte, last_byte: in_ch.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* design/lzw_back.sv */
// Back end: dictionary lookup by linear-probed hash table with epoch tags,
// entry insert, width growth and clear/freeze. Issues codes to the packer.
// Depends on lzw_pkg and lzw_ram.
`default_nettype none
module lzw_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lzw_pkg::cfg_t       cfg,
	input  wire logic                head_valid,
	input  wire lzw_pkg::item_t      head,
	output logic                     pop,
	output lzw_pkg::code_req_t       req,
	input  wire logic                req_ready
);
	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PROBE = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_LAST  = 3'd4;

	logic [2:0]                  state_q;
	logic [lzw_pkg::CODE_W-1:0]  prefix_q;
	logic                        pvalid_q;
	logic [lzw_pkg::NC_W-1:0]    next_q;
	logic [lzw_pkg::CW_W-1:0]    cw_q;
	logic [lzw_pkg::TAG_W-1:0]   tag_q;
	logic                        sweep_req_q;
	logic [lzw_pkg::CODE_W-1:0]  addr_q;
	logic [7:0]                  byte_q;
	logic                        last_q;
	logic [lzw_pkg::CODE_W-1:0]  ecode_q;
	logic [lzw_pkg::CW_W-1:0]    ew_q;

	logic [lzw_pkg::CODE_W-1:0]  raddr, hash;
	logic                        we;
	logic [lzw_pkg::CODE_W-1:0]  waddr;
	lzw_pkg::slot_t              wslot, rslot;
	logic [lzw_pkg::SLOT_W-1:0]  rdata;
	logic [lzw_pkg::CW_W-1:0]    eff;
	logic [lzw_pkg::NC_W-1:0]    limit, next_inc, grow_at;
	logic [lzw_pkg::KEY_W-1:0]   key;
	logic                        hit, empty;

	always_comb begin
		eff = cfg.width_cap;
		if (cfg.width_cap < lzw_pkg::MIN_WIDTH) eff = lzw_pkg::MIN_WIDTH;
		if (cfg.width_cap > lzw_pkg::MAX_WIDTH) eff = lzw_pkg::MAX_WIDTH;
	end

	assign limit    = lzw_pkg::NC_W'(1) << eff;
	assign next_inc = next_q + lzw_pkg::NC_W'(1);
	assign grow_at  = lzw_pkg::NC_W'(1) << cw_q;
	assign hash     = prefix_q ^ (lzw_pkg::CODE_W'(head.data_byte) << (lzw_pkg::CODE_W - 8));
	assign key      = {prefix_q, byte_q};
	assign rslot    = lzw_pkg::slot_t'(rdata);
	assign hit      = (rslot.tag == tag_q) && (rslot.key == key);
	assign empty    = (rslot.tag != tag_q);

	always_comb begin
		case (state_q)
			ST_IDLE:  raddr = hash;
			ST_PROBE: raddr = addr_q + lzw_pkg::CODE_W'(1);
			default:  raddr = addr_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wslot = '{tag: tag_q, code: next_q[lzw_pkg::CODE_W-1:0], key: key};
		if (state_q == ST_CLR) begin
			we    = 1'b1;
			wslot = '{tag: lzw_pkg::TAG_EMPTY, code: '0, key: '0};
		end else if (state_q == ST_PROBE && empty && next_q < limit) begin
			we = 1'b1;
		end
	end

	lzw_ram #(.WIDTH(lzw_pkg::SLOT_W), .DEPTH(lzw_pkg::DEPTH)) u_dict (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (lzw_pkg::SLOT_W'(wslot)),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pop = (state_q == ST_IDLE) && head_valid && !sweep_req_q;

	always_comb begin
		req.valid = (state_q == ST_EMIT) || (state_q == ST_LAST);
		req.code  = (state_q == ST_LAST) ? prefix_q : ecode_q;
		req.width = (state_q == ST_LAST) ? cw_q : ew_q;
		req.flush = (state_q == ST_LAST);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= head.data_byte;
			last_q <= head.last_byte;
		end
		if (state_q == ST_PROBE && empty) begin
			ecode_q <= prefix_q;
			ew_q    <= cw_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			addr_q      <= '0;
			prefix_q    <= '0;
			pvalid_q    <= 1'b0;
			next_q      <= lzw_pkg::FIRST_CODE;
			cw_q        <= lzw_pkg::MIN_WIDTH;
			tag_q       <= lzw_pkg::TAG_FIRST;
			sweep_req_q <= 1'b0;
		end else begin
			// the clearing pass always walks the whole table from slot 0
			if (state_q == ST_CLR)
				addr_q <= addr_q + lzw_pkg::CODE_W'(1);
			else if (state_q == ST_IDLE && sweep_req_q)
				addr_q <= '0;
			else
				addr_q <= raddr;
			unique case (state_q)
				ST_CLR: begin
					if (addr_q == {lzw_pkg::CODE_W{1'b1}}) begin
						state_q     <= ST_IDLE;
						sweep_req_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (sweep_req_q) begin
						state_q <= ST_CLR;
					end else if (head_valid) begin
						if (!pvalid_q) begin
							prefix_q <= lzw_pkg::CODE_W'(head.data_byte);
							pvalid_q <= 1'b1;
							state_q  <= head.last_byte ? ST_LAST : ST_IDLE;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (hit) begin
						prefix_q <= rslot.code;
						state_q  <= last_q ? ST_LAST : ST_IDLE;
					end else if (empty) begin
						if (next_q < limit) begin
							next_q <= next_inc;
							if (next_inc == grow_at && cw_q < eff)
								cw_q <= cw_q + lzw_pkg::CW_W'(1);
						end else if (cfg.reset_on_full) begin
							next_q <= lzw_pkg::FIRST_CODE;
							cw_q   <= lzw_pkg::MIN_WIDTH;
							if (tag_q == lzw_pkg::TAG_MAX) begin
								tag_q       <= lzw_pkg::TAG_FIRST;
								sweep_req_q <= 1'b1;
							end else begin
								tag_q <= tag_q + lzw_pkg::TAG_W'(1);
							end
						end
						prefix_q <= lzw_pkg::CODE_W'(byte_q);
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (req_ready) state_q <= last_q ? ST_LAST : ST_IDLE;
				end
				ST_LAST: begin
					if (req_ready) begin
						prefix_q <= '0;
						pvalid_q <= 1'b0;
						next_q   <= lzw_pkg::FIRST_CODE;
						cw_q     <= lzw_pkg::MIN_WIDTH;
						if (tag_q == lzw_pkg::TAG_MAX) begin
							tag_q       <= lzw_pkg::TAG_FIRST;
							sweep_req_q <= 1'b1;
						end else begin
							tag_q <= tag_q + lzw_pkg::TAG_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/lzw_pack.sv */
// Bit packer: appends codes LSB first and ships whole bytes through an
// output register; a flush code drains the partial byte and marks the last.
// Depends on lzw_pkg and lzw_chan_if.
`default_nettype none
module lzw_pack (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lzw_pkg::code_req_t req,
	output logic                    req_ready,
	lzw_out_if.source               out_ch
);
	logic [lzw_pkg::ACC_W-1:0]  acc_q;
	logic [lzw_pkg::CNT_W-1:0]  cnt_q;
	logic                       flush_q;
	logic                       ov_q, ol_q;
	logic [7:0]                 ob_q;
	logic                       free, avail, full_byte;
	logic [lzw_pkg::CODE_W-1:0] mask;

	assign full_byte = (cnt_q >= lzw_pkg::CNT_W'(8));
	assign free      = !ov_q || out_ch.ready;
	assign avail     = full_byte || (flush_q && cnt_q != '0);
	assign req_ready = !full_byte && !flush_q;
	assign mask      = lzw_pkg::CODE_W'((lzw_pkg::NC_W'(1) << req.width) - lzw_pkg::NC_W'(1));

	assign out_ch.valid    = ov_q;
	assign out_ch.out_byte = ob_q;
	assign out_ch.last_out = ol_q;

	always_ff @(posedge clk) begin
		if (avail && free) begin
			ob_q <= acc_q[7:0];
			ol_q <= flush_q && (cnt_q <= lzw_pkg::CNT_W'(8));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (avail && free) begin
				ov_q <= 1'b1;
				if (flush_q && cnt_q <= lzw_pkg::CNT_W'(8)) begin
					acc_q   <= '0;
					cnt_q   <= '0;
					flush_q <= 1'b0;
				end else begin
					acc_q <= acc_q >> 8;
					cnt_q <= cnt_q - lzw_pkg::CNT_W'(8);
				end
			end else begin
				if (free) ov_q <= 1'b0;
				if (req.valid && req_ready) begin
					acc_q   <= acc_q | (lzw_pkg::ACC_W'(req.code & mask) << cnt_q[2:0]);
					cnt_q   <= cnt_q + lzw_pkg::CNT_W'(req.width);
					flush_q <= req.flush;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* design/lzw_stream_encoder_core.sv */
// Top level of the LZW stream encoder: front end, back end and bit packer.
// Depends on lzw_pkg, lzw_chan_if, lzw_front, lzw_back and lzw_pack.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      data_byte[7:0], last_byte
//  out_ch    out  valid/ready      out_byte[7:0], last_out
//  apb       in   psel/penable     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A hit takes an item through IDLE and PROBE; a miss adds EMIT, waiting on the
// packer; extra probes stay in PROBE (linear probing, one RAM read a cycle).
// After reset a clearing pass tags all 4096 slots empty; the same pass runs
// again each time the 8-bit epoch tag wraps (every 255 clears).
// The two-entry input queue and the output register let each side stall alone.
`default_nettype none
module lzw_stream_encoder_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	lzw_in_if.sink                          in_ch,
	lzw_out_if.source                       out_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lzw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	lzw_pkg::cfg_t      cfg;
	lzw_pkg::item_t     head;
	logic               head_valid, pop, req_ready;
	lzw_pkg::code_req_t req;

	assign pready = 1'b1;

	lzw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	lzw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.req        (req),
		.req_ready  (req_ready)
	);

	lzw_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (req_ready),
		.out_ch    (out_ch)
	);
endmodule
`default_nettype wire

/* tb/lzw_encoder_scoreboard.sv */
// Scoreboard for the LZW stream encoder: tracks register writes, predicts the
// packed output bytes of every accepted input item and checks the output channel.
// Depends on lzw_pkg.
`default_nettype none
module lzw_encoder_scoreboard (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic [7:0]                 in_data,
	input  wire logic                       in_last,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic [7:0]                 out_data,
	input  wire logic                       out_last,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic                       pready,
	input  wire logic [lzw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output int                              mismatches,
	output int                              outstanding
);
	typedef struct {
		logic [7:0] out_byte;
		logic       last_out;
	} packed_byte_t;

	packed_byte_t expected_bytes[$];

	logic [4:0]  width_cap;
	logic        reset_on_full;
	logic [11:0] prefix_code;
	logic        prefix_valid;
	int          next_code;
	int          code_width;
	logic [6:0]  pend_bits;
	int          pend_count;
	logic [19:0] dict [256:4095];
	int          emitted;

	assign outstanding = expected_bytes.size();

	function automatic int eff_width();
		if (width_cap < 9) return 9;
		if (width_cap > lzw_pkg::CODE_W) return lzw_pkg::CODE_W;
		return width_cap;
	endfunction

	task automatic pack_code(input logic [11:0] code);
		logic [31:0] acc;
		int          cnt;
		packed_byte_t b;
		acc = 32'(pend_bits) | ((32'(code) & ((32'd1 << code_width) - 1)) << pend_count);
		cnt = pend_count + code_width;
		while (cnt >= 8) begin
			b.out_byte = acc[7:0];
			b.last_out = 1'b0;
			expected_bytes.push_back(b);
			emitted++;
			acc = acc >> 8;
			cnt -= 8;
		end
		pend_bits = acc[6:0];
		pend_count = cnt;
	endtask

	task automatic new_stream();
		prefix_code = '0;
		prefix_valid = 1'b0;
		next_code = 256;
		code_width = 9;
		pend_bits = '0;
		pend_count = 0;
	endtask

	task automatic encode_byte(input logic [7:0] c, input logic last);
		logic [19:0] key;
		int          limit;
		int          hit;
		packed_byte_t b;
		limit = 1 << eff_width();
		emitted = 0;
		if (!prefix_valid) begin
			prefix_code = 12'(c);
			prefix_valid = 1'b1;
		end else begin
			key = {prefix_code, c};
			hit = 0;
			for (int k = 256; k < next_code && k < 4096; k++) begin
				if (dict[k] == key) begin
					hit = k;
					break;
				end
			end
			if (hit != 0) begin
				prefix_code = 12'(hit);
			end else begin
				pack_code(prefix_code);
				if (next_code < limit) begin
					dict[next_code] = key;
					next_code++;
					if (next_code == (1 << code_width) && code_width < eff_width())
						code_width++;
				end else if (reset_on_full) begin
					next_code = 256;
					code_width = 9;
				end
				prefix_code = 12'(c);
			end
		end
		if (last) begin
			pack_code(prefix_code);
			if (pend_count > 0) begin
				b.out_byte = 8'(pend_bits);
				b.last_out = 1'b0;
				expected_bytes.push_back(b);
				emitted++;
			end
			if (emitted > 0)
				expected_bytes[$].last_out = 1'b1;
			new_stream();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_byte_t e;
		if (!arst_n) begin
			width_cap = lzw_pkg::WIDTH_CAP_RST;
			reset_on_full = 1'b0;
			mismatches = 0;
			expected_bytes.delete();
			new_stream();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == lzw_pkg::REG_WIDTH_CAP)
					width_cap = pwdata[4:0];
				else if (paddr == lzw_pkg::REG_FULL_MODE)
					reset_on_full = pwdata[0];
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected output byte %h last %b", $time, out_data, out_last);
					mismatches++;
				end else begin
					e = expected_bytes.pop_front();
					if (e.out_byte !== out_data) begin
						$display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
							out_data);
						mismatches++;
					end
					if (e.last_out !== out_last) begin
						$display("%0t: last_out expected %b actual %b", $time, e.last_out,
							out_last);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				encode_byte(in_data, in_last);
		end
	end
endmodule
`default_nettype wire

/* tb/lzw_stream_encoder_core_tb.sv */
// Testbench top for the LZW stream encoder: clock, reset, register writes,
// byte streams with random gaps and stalls, and the final verdict.
// Depends on lzw_pkg, lzw_chan_if, lzw_stream_encoder_core and lzw_encoder_scoreboard.
`default_nettype none
module lzw_stream_encoder_core_tb;
	localparam int IDLE_LIMIT = 30000;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [lzw_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	int                         mismatches;
	int                         outstanding;
	int                         idle_cycles;
	logic                       calm;
	logic                       long_hold;
	bit                         hold_done;
	int                         rx_stall;

	lzw_in_if  in_ch ();
	lzw_out_if out_ch ();

	lzw_stream_encoder_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lzw_encoder_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data_byte),
		.in_last(in_ch.last_byte),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.out_byte),
		.out_last(out_ch.last_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// output side: short random stalls, a few long ones, one long hold on request
	always @(negedge clk) begin
		if (long_hold && !hold_done) begin
			hold_done = 1'b1;
			rx_stall = 300;
		end
		if (rx_stall > 0) begin
			out_ch.ready = 1'b0;
			rx_stall--;
		end else if (!calm && $urandom_range(3) == 0) begin
			out_ch.ready = 1'b0;
			rx_stall = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3);
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	task automatic reg_write(input logic [lzw_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(3) == 0) begin
			in_ch.valid = 1'b0;
			repeat (($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(3, 1))
				@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data_byte = b;
		in_ch.last_byte = last;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// span 0 draws from all 256 values, else from a small alphabet to get hits
	task automatic send_stream(input int len, input int span);
		logic [7:0] base;
		base = 8'($urandom);
		for (int i = 0; i < len; i++)
			send_byte(span == 0 ? 8'($urandom) : base + 8'($urandom_range(span - 1)),
				i == len - 1);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(input logic [4:0] bits, input logic clr);
		drain();
		reg_write(lzw_pkg::REG_WIDTH_CAP, 32'(bits));
		reg_write(lzw_pkg::REG_FULL_MODE, 32'(clr));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		calm = 1'b0;
		long_hold = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: lone bytes, extremes, repeated patterns
		calm = 1'b1;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		for (int i = 0; i < 8; i++)
			send_byte(8'h41, i == 7);
		for (int i = 0; i < 10; i++)
			send_byte(i[0] ? 8'h55 : 8'hAA, i == 9);
		in_ch.valid = 1'b0;
		calm = 1'b0;
		drain();

		for (int s = 0; s < 6; s++)
			send_stream($urandom_range(16, 2), $urandom_range(3) == 0 ? 0 : 3);

		// 9-bit cap, clear on full
		set_mode(5'd9, 1'b1);
		send_stream(20, 0);
		// 9-bit cap, freeze on full
		set_mode(5'd9, 1'b0);
		send_stream(15, 0);
		// cap above the built maximum, with a long receiver hold
		set_mode(5'd31, 1'b1);
		long_hold = 1'b1;
		send_stream(25, 6);
		// cap below the minimum width, back-to-back items
		set_mode(5'd0, 1'b0);
		calm = 1'b1;
		send_stream(10, 4);
		calm = 1'b0;
		set_mode(5'd16, 1'b0);
		send_stream(10, 0);

		in_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
